FILE: design/lkv_pkg.sv
package lkv_pkg;

    // Store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // One stored entry: key, value and recency rank (0 = most recent)
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] rank;
    } entry_t;

    // Scan summary handed from the scan tracker to the sequencer
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic [VAL_W-1:0] hit_value;
        logic             vic_found;
        logic [IDX_W-1:0] vic_idx;
        logic [IDX_W-1:0] vic_rank;
    } scan_res_t;

endpackage

FILE: design/lkv_ram.sv
module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/lkv_scan.sv
module lkv_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      sample,
    input  logic [lkv_pkg::IDX_W-1:0] idx,
    input  logic                      ent_valid,
    input  lkv_pkg::entry_t           ent,
    input  logic [lkv_pkg::KEY_W-1:0] req_key,
    output lkv_pkg::scan_res_t        res
);
    import lkv_pkg::*;

    logic             hit_reg, hit_next;
    logic             vic_found_reg, vic_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0] hit_value_reg, hit_value_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [IDX_W-1:0] vic_rank_reg, vic_rank_next;
    logic             match;
    logic             vic_upd;

    // First valid entry holding the key; oldest valid entry (first on tie)
    assign match   = sample && ent_valid && (ent.key == req_key) && !hit_reg;
    assign vic_upd = sample && ent_valid && (!vic_found_reg || (ent.rank > vic_rank_reg));

    always_comb
    begin
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        hit_value_next = hit_value_reg;
        vic_found_next = vic_found_reg;
        vic_idx_next   = vic_idx_reg;
        vic_rank_next  = vic_rank_reg;
        if (clear)
        begin
            hit_next       = 1'b0;
            vic_found_next = 1'b0;
        end
        else
        begin
            if (match)
            begin
                hit_next       = 1'b1;
                hit_idx_next   = idx;
                hit_rank_next  = ent.rank;
                hit_value_next = ent.value;
            end
            if (vic_upd)
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = idx;
                vic_rank_next  = ent.rank;
            end
        end
    end

    // Flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            vic_found_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            vic_found_reg <= vic_found_next;
        end
    end

    // Captured payload
    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        hit_value_reg <= hit_value_next;
        vic_idx_reg   <= vic_idx_next;
        vic_rank_reg  <= vic_rank_next;
    end

    assign res.hit       = hit_reg;
    assign res.hit_idx   = hit_idx_reg;
    assign res.hit_rank  = hit_rank_reg;
    assign res.hit_value = hit_value_reg;
    assign res.vic_found = vic_found_reg;
    assign res.vic_idx   = vic_idx_reg;
    assign res.vic_rank  = vic_rank_reg;

endmodule

FILE: design/lru_key_value_cache_core.sv
// Results: a get's result is strobed on done when the lookup sweep ends; a hit's rank update follows.
// Occupancy: a get that misses occupies the block for the lookup sweep only; every other
// request for a lookup sweep, then a rank update sweep, one entry per cycle through the
// entry memory (one read port, one write port). busy is high for that whole time.
// Reset: all entries invalid, occupancy zero, capacity 16. done has no backpressure:
// each result is valid for exactly one cycle.
module lru_key_value_cache_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             op,
    input  logic signed [lkv_pkg::KEY_W-1:0] key,
    input  logic signed [lkv_pkg::VAL_W-1:0] value,
    output logic                             done,
    output logic                             hit,
    output logic signed [lkv_pkg::VAL_W-1:0] value_out,
    input  logic                             cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]        cfg_wdata
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    logic [IDX_W-1:0] rank_reg, rank_next;
    logic             inc_all_reg, inc_all_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic             done_reg, done_next;
    logic             hit_reg, hit_next;
    logic [VAL_W-1:0] vout_reg, vout_next;
    logic [CAP_W-1:0] cap_reg;

    logic             accept;
    logic             issue;
    logic             last_data;
    logic [CMP_W-1:0] eff_cap;
    logic [IDX_W-1:0] free_idx;
    logic             ram_we;
    entry_t           rd_ent;
    entry_t           wr_ent;
    scan_res_t        scan_res;
    logic [$bits(entry_t)-1:0] ram_rdata;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                       && (ptr_reg != CNT_W'(ENTRIES));
    assign last_data = rd_vld_reg && (rd_idx_reg == IDX_W'(ENTRIES - 1));
    assign rd_ent    = entry_t'(ram_rdata);

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Effective capacity: zero counts as one, saturate at the store size
    always_comb
    begin
        eff_cap = CMP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Entry memory
    lkv_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_idx_reg),
        .wdata (wr_ent),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Lookup / victim tracker
    lkv_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .sample    (rd_vld_reg && (state_reg == ST_SCAN)),
        .idx       (rd_idx_reg),
        .ent_valid (valid_reg[rd_idx_reg]),
        .ent       (rd_ent),
        .req_key   (key_reg),
        .res       (scan_res)
    );

    // Read-modify-write of one entry during the update sweep
    assign ram_we = rd_vld_reg && (state_reg == ST_UPDATE);

    always_comb
    begin
        wr_ent = rd_ent;
        if (rd_idx_reg == tgt_reg)
        begin
            wr_ent.rank = '0;
            if (op_reg == OP_PUT)
            begin
                wr_ent.key   = key_reg;
                wr_ent.value = val_reg;
            end
        end
        else if (valid_reg[rd_idx_reg] && (inc_all_reg || (rd_ent.rank < rank_reg)))
        begin
            wr_ent.rank = rd_ent.rank + 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        rd_vld_next  = issue;
        rd_idx_next  = ptr_reg[IDX_W-1:0];
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        tgt_next     = tgt_reg;
        rank_next    = rank_reg;
        inc_all_next = inc_all_reg;
        valid_next   = valid_reg;
        occ_next     = occ_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        vout_next    = vout_reg;
        if (issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    ptr_next   = '0;
                    op_next    = op;
                    key_next   = key;
                    val_next   = value;
                end
            end
            ST_SCAN:
            begin
                if (last_data)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ptr_next     = '0;
                state_next   = ST_UPDATE;
                tgt_next     = scan_res.hit_idx;
                rank_next    = scan_res.hit_rank;
                inc_all_next = 1'b0;
                if (op_reg == OP_GET)
                begin
                    done_next = 1'b1;
                    hit_next  = scan_res.hit;
                    vout_next = scan_res.hit ? scan_res.hit_value : MISS_VALUE;
                    if (!scan_res.hit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!scan_res.hit)
                begin
                    if (CMP_W'(occ_reg) < eff_cap)
                    begin
                        // Fill a free slot; every resident entry ages by one
                        tgt_next             = free_idx;
                        inc_all_next         = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        occ_next             = occ_reg + 1'b1;
                    end
                    else
                    begin
                        // Evict the least recent entry
                        tgt_next  = scan_res.vic_idx;
                        rank_next = scan_res.vic_rank;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (last_data)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            op_reg      <= OP_GET;
            key_reg     <= '0;
            val_reg     <= '0;
            tgt_reg     <= '0;
            rank_reg    <= '0;
            inc_all_reg <= 1'b0;
            valid_reg   <= '0;
            occ_reg     <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            vout_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            rd_idx_reg  <= rd_idx_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            val_reg     <= val_next;
            tgt_reg     <= tgt_next;
            rank_reg    <= rank_next;
            inc_all_reg <= inc_all_next;
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            vout_reg    <= vout_next;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign value_out = vout_reg;

`ifndef SYNTH
    // Occupancy tracks the number of valid entries
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
    else $error("occupancy out of step with valid bits");

    // A result only follows the decision step
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_DECIDE))
    else $error("result strobe outside decision");

    // Memory writes only during the update sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_UPDATE))
    else $error("entry write outside update sweep");

    // An accepted request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
    else $error("request accepted without going busy");

    // A miss never returns anything but all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (vout_reg == MISS_VALUE))
    else $error("miss result carries a value");
`endif

endmodule
